FILE: rtl/mtl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_pkg
// Shared types and constants for the trapdoor label element pipeline.
// ----------------------------------------------------------------------------
package mtl_pkg;

  localparam int VALUE_W = 16;
  localparam int INDEX_W = 32;
  localparam int PROD_W  = 32;
  localparam int FUNC_W  = 2;

  // Operation selector codes.
  localparam logic [FUNC_W-1:0] FUNC_LABEL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB   = 2'd2;

  // One item as it moves down the chain. The acc field holds the running
  // residue, or a raw product inside a cell.
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] label_index;
    logic [VALUE_W-1:0] left_value;
    logic [VALUE_W-1:0] right_value;
    logic [PROD_W-1:0]  acc;
    logic [VALUE_W-1:0] operand_value;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] label_value;
    logic [VALUE_W-1:0] combined_value;
  } result_t;

endpackage : mtl_pkg
`default_nettype wire

FILE: rtl/mtl_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_prep
// Entry stages: reduce the operand modulo the modulus and load the seed.
// ----------------------------------------------------------------------------
module mtl_prep
  import mtl_pkg::*;
#(
  parameter int MODULUS = 59393
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       out_valid,
  output item_t      out_item
);

  localparam logic [63:0]        MU_WIDE = 64'h1_0000_0000 / MODULUS;
  localparam logic [PROD_W-1:0]  MU      = MU_WIDE[PROD_W-1:0];
  localparam logic [VALUE_W-1:0] MOD     = VALUE_W'(MODULUS);

  logic                v1;
  item_t               d1;
  item_t               d1_next;
  item_t               out_item_next;
  logic [PROD_W-1:0]   q1;
  logic [63:0]         qprod;
  logic [47:0]         qm;
  logic [VALUE_W:0]    diff;
  logic [VALUE_W:0]    red;

  assign qprod = 64'(in_item.operand_value) * 64'(MU);
  assign qm    = 48'(q1) * 48'(MOD);
  assign diff  = (VALUE_W+1)'(d1.operand_value) - qm[VALUE_W:0];
  assign red   = (diff >= (VALUE_W+1)'(MOD)) ? diff - (VALUE_W+1)'(MOD) : diff;

  always_comb begin
    d1_next                     = in_item;
    d1_next.acc                 = PROD_W'(in_item.acc[VALUE_W-1:0]);
    out_item_next               = d1;
    out_item_next.operand_value = red[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1       <= d1_next;
      q1       <= qprod[63:32];
      out_item <= out_item_next;
    end
  end

endmodule : mtl_prep
`default_nettype wire

FILE: rtl/mtl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_cell
// One round: multiply the running residue by the left or right value that
// the chosen index bit picks, then reduce modulo the modulus (Barrett).
// ----------------------------------------------------------------------------
module mtl_cell
  import mtl_pkg::*;
#(
  parameter int MODULUS = 59393,
  parameter int BIT_POS = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       out_valid,
  output item_t      out_item
);

  localparam logic [63:0]        MU_WIDE = 64'h1_0000_0000 / MODULUS;
  localparam logic [PROD_W-1:0]  MU      = MU_WIDE[PROD_W-1:0];
  localparam logic [VALUE_W-1:0] MOD     = VALUE_W'(MODULUS);

  logic [VALUE_W-1:0] pick;
  logic               v1;
  logic               v2;
  item_t              d1;
  item_t              d2;
  item_t              d1_next;
  item_t              out_item_next;
  logic [PROD_W-1:0]  q2;
  logic [63:0]        qprod;
  logic [47:0]        qm;
  logic [VALUE_W+1:0] diff;
  logic [VALUE_W+1:0] red;

  assign pick  = in_item.label_index[BIT_POS] ? in_item.left_value : in_item.right_value;
  assign qprod = 64'(d1.acc) * 64'(MU);
  // The quotient estimate is low by at most one, so one subtraction fixes it.
  assign qm    = 48'(q2) * 48'(MOD);
  assign diff  = d2.acc[VALUE_W+1:0] - qm[VALUE_W+1:0];
  assign red   = (diff >= (VALUE_W+2)'(MOD)) ? diff - (VALUE_W+2)'(MOD) : diff;

  always_comb begin
    d1_next           = in_item;
    d1_next.acc       = PROD_W'(in_item.acc[VALUE_W-1:0]) * PROD_W'(pick);
    out_item_next     = d2;
    out_item_next.acc = PROD_W'(red[VALUE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1       <= d1_next;
      d2       <= d1;
      q2       <= qprod[63:32];
      out_item <= out_item_next;
    end
  end

endmodule : mtl_cell
`default_nettype wire

FILE: rtl/mtl_combine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtl_combine
// Final stage: form the label and apply the modular add or subtract, or pass the label on.
// ----------------------------------------------------------------------------
module mtl_combine
  import mtl_pkg::*;
#(
  parameter int MODULUS = 59393
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       out_valid,
  output result_t    out_result
);

  localparam logic [VALUE_W:0] MOD = (VALUE_W+1)'(MODULUS);

  logic [VALUE_W-1:0] label;
  logic [VALUE_W:0]   sum;
  logic [VALUE_W:0]   comb;

  assign label = in_item.acc[VALUE_W-1:0];
  assign sum   = (VALUE_W+1)'(in_item.operand_value) + (VALUE_W+1)'(label);

  always_comb begin
    case (in_item.func)
      FUNC_ADD: begin
        comb = (sum >= MOD) ? sum - MOD : sum;
      end
      FUNC_SUB: begin
        if (in_item.operand_value >= label) begin
          comb = (VALUE_W+1)'(in_item.operand_value - label);
        end else begin
          comb = (VALUE_W+1)'(in_item.operand_value) + MOD - (VALUE_W+1)'(label);
        end
      end
      default: begin
        comb = (VALUE_W+1)'(label);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result.label_value    <= label;
      out_result.combined_value <= comb[VALUE_W-1:0];
    end
  end

endmodule : mtl_combine
`default_nettype wire

FILE: rtl/modular_trapdoor_label_element_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_trapdoor_label_element_top
// Streaming trapdoor label element with modular accumulate and subtract.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Width (tdata/tuser)  Contents
//   s_*      in         96 / 2               one vector position per transaction
//   m_*      out        32 / -               label and combined value
//
// One transaction enters per cycle and one result leaves per cycle while the
// output is not stalled. The chain has INDEX_BITS cells, each a three-stage
// multiply and Barrett reduction round; a result passes through the two
// operand-reduction stages, the cells, the combine stage and the output
// register. The cell multipliers set the clock, not the rate.
// Reset (rst, synchronous) clears the valid bits of every stage and empties
// the two-entry output buffer; nothing else needs clearing.
// When the output is stalled the buffer absorbs one more result while input
// is still taken; the whole chain holds only once both entries are full.
// ----------------------------------------------------------------------------
module modular_trapdoor_label_element_top
  import mtl_pkg::*;
#(
  parameter int MODULUS    = 59393,
  parameter int INDEX_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [31:0] label_index, [47:32] left_value, [63:48] right_value,
  // [79:64] seed_value, [95:80] operand_value
  input  wire logic [95:0] s_tdata,
  // [1:0] func
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [15:0] label_value, [31:16] combined_value
  output logic [31:0]      m_tdata
);

  logic    en;
  item_t   in_item;
  logic    link_valid [INDEX_BITS+1];
  item_t   link_item  [INDEX_BITS+1];
  logic    res_valid;
  result_t res;

  // Two-entry output buffer: slot0 is the head shown on the master side.
  result_t     slot0;
  result_t     slot1;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  // The chain moves as one; it stops only when the buffer has no room.
  assign en       = (count != 2'd2);
  assign s_tready = en;

  always_comb begin
    in_item               = '0;
    in_item.func          = s_tuser;
    in_item.label_index   = s_tdata[31:0];
    in_item.left_value    = s_tdata[47:32];
    in_item.right_value   = s_tdata[63:48];
    in_item.acc           = PROD_W'(s_tdata[79:64]);
    in_item.operand_value = s_tdata[95:80];
  end

  mtl_prep #(
    .MODULUS (MODULUS)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_item   (in_item),
    .out_valid (link_valid[0]),
    .out_item  (link_item[0])
  );

  for (genvar i = 0; i < INDEX_BITS; i++) begin : g_cell
    mtl_cell #(
      .MODULUS (MODULUS),
      .BIT_POS (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (link_valid[i]),
      .in_item   (link_item[i]),
      .out_valid (link_valid[i+1]),
      .out_item  (link_item[i+1])
    );
  end

  mtl_combine #(
    .MODULUS (MODULUS)
  ) u_combine (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (link_valid[INDEX_BITS]),
    .in_item    (link_item[INDEX_BITS]),
    .out_valid  (res_valid),
    .out_result (res)
  );

  assign push = res_valid && en;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (pop && push) begin
      // A push with a pop only happens with one entry held.
      slot0 <= res;
    end
  end

  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = {slot0.combined_value, slot0.label_value};

endmodule : modular_trapdoor_label_element_top
`default_nettype wire

FILE: tb/sv/modular_trapdoor_label_element_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_trapdoor_label_element_top_tb
// Self-checking bench for the trapdoor label element pipeline.
// ----------------------------------------------------------------------------
// A queue of pending vector positions is filled up front: a directed set
// that covers the field extremes, every func code and the wrap cases of the
// modular add and subtract, followed by random positions. A clocked driver
// feeds the slave stream from that queue and computes the expected label and
// combined value of every accepted transaction. A clocked monitor compares
// each master-side transaction with the oldest prediction. Both sides idle
// in short random bursts, the receiver also holds off once for a long
// stretch so the chain backs up, and the sender waits twice for a full drain.
// ----------------------------------------------------------------------------
module modular_trapdoor_label_element_top_tb;
  import mtl_pkg::*;

  localparam int        INDEX_BITS   = 32;
  localparam bit [31:0] LABEL_MOD    = 32'd59393;
  localparam int        PIPE_LATENCY = 3 * INDEX_BITS + 4;

  // func code that the block leaves unused; it must act as a plain label.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1750;
  localparam int MAX_ITEMS    = 4096;
  localparam int CALM_TAIL    = 300;     // no idling on either side here
  localparam int LONG_HOLD_AT = 300;     // accepted count that starts it
  localparam int LONG_HOLD    = 400;     // cycles of receiver hold-off
  localparam int DRAIN_AT     = 900;     // random item that waits for drain
  localparam int LIMIT_CYCLES = 200000;

  // One pending vector position. drain_first makes the driver hold it back
  // until every earlier result has come out of the block.
  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] label_index;
    logic [VALUE_W-1:0] left_value;
    logic [VALUE_W-1:0] right_value;
    logic [VALUE_W-1:0] seed_value;
    logic [VALUE_W-1:0] operand_value;
    bit                 drain_first;
  } position_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  position_t position_q[$];
  position_t driven_position;
  result_t   predicted_results[MAX_ITEMS];
  result_t   oldest_result;

  int n_accepted  = 0;    // slave-side transactions, written by the driver
  int n_received  = 0;    // master-side transactions, written by the monitor
  int total_items = 0;
  int error_count = 0;
  int cycle_count = 0;
  int sender_idle = 0;
  int hold_cycles = 0;
  bit long_hold_done = 1'b0;
  bit took;
  bit tx_quiet;
  bit rx_quiet;

  modular_trapdoor_label_element_top #(
    .MODULUS   (59393),
    .INDEX_BITS(INDEX_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Label: the seed multiplied, round by round, by the left value where the
  // index bit is one and the right value where it is zero, all mod 59393.
  // The operand is reduced first, then added or subtracted per func.
  function automatic result_t predict_result(input position_t p);
    bit [31:0] running;
    bit [31:0] product;
    bit [31:0] pick;
    bit [31:0] opnd;
    bit [31:0] comb;
    result_t   r;
    running = {16'd0, p.seed_value};
    for (int b = 0; b < INDEX_BITS; b++) begin
      pick    = p.label_index[b] ? {16'd0, p.left_value} : {16'd0, p.right_value};
      product = running * pick;
      running = product % LABEL_MOD;
    end
    opnd = {16'd0, p.operand_value} % LABEL_MOD;
    case (p.func)
      FUNC_ADD: begin
        comb = opnd + running;
        if (comb >= LABEL_MOD) comb = comb - LABEL_MOD;
      end
      FUNC_SUB: begin
        comb = (opnd >= running) ? opnd - running : opnd + LABEL_MOD - running;
      end
      default: begin
        comb = running;
      end
    endcase
    r.label_value    = running[15:0];
    r.combined_value = comb[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int item,
                                 input int got, input int want);
    $display("MISMATCH %s at result %0d: got 0x%0h, want 0x%0h",
             what, item, got, want);
    error_count++;
  endtask

  task automatic add_position(input logic [1:0] func, input logic [31:0] idx,
                              input logic [15:0] lv, input logic [15:0] rv,
                              input logic [15:0] sv, input logic [15:0] ov,
                              input bit drain);
    position_t p;
    p.func          = func;
    p.label_index   = idx;
    p.left_value    = lv;
    p.right_value   = rv;
    p.seed_value    = sv;
    p.operand_value = ov;
    p.drain_first   = drain;
    position_q.push_back(p);
  endtask

  // Mostly proper residues, sometimes the full 16-bit range so that the
  // out-of-range paths and every high bit get exercised, sometimes an edge.
  function automatic logic [15:0] random_value();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 12) return 16'($urandom_range(0, 59392));
    if (sel < 14) return 16'($urandom);
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd59392;
      3: return 16'd59393;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [1:0] random_func();
    if ($urandom_range(0, 15) == 0) return FUNC_UNUSED;
    case ($urandom_range(0, 2))
      0: return FUNC_LABEL;
      1: return FUNC_ADD;
      default: return FUNC_SUB;
    endcase
  endfunction

  function automatic logic [31:0] random_index();
    case ($urandom_range(0, 15))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Driver. A new transaction is only put up once the previous one has been
  // accepted, so tvalid never drops while a transaction is waiting. Idle
  // bursts are inserted between transactions, never in the middle of one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid    <= 1'b0;
      sender_idle <= 0;
    end else begin
      took = s_tvalid && s_tready;
      if (took) begin
        predicted_results[n_accepted] = predict_result(driven_position);
        n_accepted <= n_accepted + 1;
      end
      // Stretches without idling, and none at all in the closing part.
      tx_quiet = (n_accepted + CALM_TAIL >= total_items) || ((n_accepted / 200) % 4 == 3);
      if (!s_tvalid || took) begin
        if (sender_idle > 0) begin
          sender_idle <= sender_idle - 1;
          s_tvalid    <= 1'b0;
        end else if (position_q.size() == 0 ||
                     (position_q[0].drain_first && n_accepted + took != n_received)) begin
          s_tvalid <= 1'b0;
        end else begin
          driven_position = position_q.pop_front();
          s_tdata  <= {driven_position.operand_value, driven_position.seed_value,
                       driven_position.right_value, driven_position.left_value,
                       driven_position.label_index};
          s_tuser  <= driven_position.func;
          s_tvalid <= 1'b1;
          if (!tx_quiet && $urandom_range(0, 5) == 0)
            sender_idle <= $urandom_range(1, 4);
        end
      end
    end
  end

  // Receiver readiness. Once, after enough transactions have gone in, it
  // holds off long enough for the chain and its output buffer to fill and
  // stall the input; otherwise it drops tready in short random bursts.
  always @(posedge clk) begin
    rx_quiet = (n_received + CALM_TAIL >= total_items) || ((n_received / 200) % 4 == 1);
    if (rst) begin
      m_tready       <= 1'b0;
      hold_cycles    <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && n_accepted >= LONG_HOLD_AT) begin
      m_tready       <= 1'b0;
      hold_cycles    <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
    end else if (hold_cycles > 0) begin
      m_tready    <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_quiet) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready    <= 1'b0;
      hold_cycles <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor. Each master-side transaction is matched against the oldest
  // prediction; m_tdata holds label_value low and combined_value high.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (n_received >= n_accepted) begin
        report_mismatch("unexpected result", n_received, m_tdata, 0);
      end else begin
        oldest_result = predicted_results[n_received];
        if (m_tdata[15:0] !== oldest_result.label_value)
          report_mismatch("label_value", n_received, m_tdata[15:0],
                          oldest_result.label_value);
        if (m_tdata[31:16] !== oldest_result.combined_value)
          report_mismatch("combined_value", n_received, m_tdata[31:16],
                          oldest_result.combined_value);
      end
      n_received <= n_received + 1;
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // Directed part: a right value of one over a zero index gives the seed
    // back, an all-ones index uses only the left value.
    add_position(FUNC_LABEL, 32'h0000_0000, 16'd0,     16'd1,     16'd1,     16'd0,     1'b0);
    add_position(FUNC_LABEL, 32'hFFFF_FFFF, 16'd2,     16'd0,     16'd1,     16'd0,     1'b0);
    add_position(FUNC_ADD,   32'hAAAA_AAAA, 16'd59392, 16'd59392, 16'd59392, 16'd59392, 1'b0);
    add_position(FUNC_SUB,   32'h5555_5555, 16'd3,     16'd7,     16'd1,     16'd0,     1'b0);
    // Seed of zero forces a zero label; subtract then returns the operand.
    add_position(FUNC_SUB,   32'h1234_5678, 16'd9,     16'd11,    16'd0,     16'd59392, 1'b0);
    add_position(FUNC_UNUSED, 32'hDEAD_BEEF, 16'd17,   16'd23,    16'd1,     16'd4000,  1'b0);
    // Residues at and above the modulus are used as they come.
    add_position(FUNC_ADD,   32'hFFFF_0000, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0);
    add_position(FUNC_SUB,   32'h0000_FFFF, 16'hFFFF,  16'd59393, 16'hFFFF,  16'hFFFF,  1'b0);
    add_position(FUNC_LABEL, 32'hF0F0_F0F0, 16'd59393, 16'hFFFF,  16'd59393, 16'hFFFF,  1'b0);
    // An operand equal to the modulus reduces to zero.
    add_position(FUNC_ADD,   32'h8000_0000, 16'd5,     16'd1,     16'd1,     16'd59393, 1'b0);
    add_position(FUNC_SUB,   32'h0000_0001, 16'd5,     16'd1,     16'd1,     16'd59393, 1'b0);
    add_position(FUNC_LABEL, 32'h0000_0000, 16'd0,     16'd0,     16'd0,     16'd0,     1'b0);
    // Add wraps to zero, subtract borrows to the top residue, and an
    // operand equal to the label subtracts to zero.
    add_position(FUNC_ADD,   32'hCAFE_F00D, 16'd1,     16'd1,     16'd1,     16'd59392, 1'b0);
    add_position(FUNC_SUB,   32'hCAFE_F00D, 16'd1,     16'd1,     16'd1,     16'd0,     1'b0);
    add_position(FUNC_SUB,   32'h0F0F_0F0F, 16'd1,     16'd1,     16'd5,     16'd5,     1'b0);
    add_position(FUNC_ADD,   32'h7FFF_FFFF, 16'd59392, 16'd2,     16'd1,     16'd1,     1'b0);
    add_position(FUNC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0);

    // Random part. The first random position and one later on wait until
    // the block has emptied completely.
    for (int i = 0; i < RANDOM_ITEMS; i++)
      add_position(random_func(), random_index(), random_value(), random_value(),
                   random_value(), random_value(), (i == 0) || (i == DRAIN_AT));
    total_items = position_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < total_items) @(posedge clk);
    while (n_received < n_accepted) @(posedge clk);
    // Give any stray result time to show up.
    repeat (PIPE_LATENCY + 50) @(posedge clk);
    if (n_received < n_accepted)
      report_mismatch("missing results", n_received, n_received, n_accepted);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: modular_trapdoor_label_element_top.f
rtl/mtl_pkg.sv
rtl/mtl_prep.sv
rtl/mtl_cell.sv
rtl/mtl_combine.sv
rtl/modular_trapdoor_label_element_top.sv
tb/sv/modular_trapdoor_label_element_top_tb.sv
